// ===== src/qdc_pkg.sv =====
// ----------------------------------------------------------------------------
// qdc_pkg
// Shared types and constants for the charge converter event word demux:
// word type codes, field positions, register indexes and widths.
// ----------------------------------------------------------------------------
package qdc_pkg;

	// Default sizing
	localparam int LOGICAL_CHANNELS_DEF = 32;
	localparam int VALUE_WIDTH_DEF      = 12;

	// Readout word layout
	localparam int WORD_W      = 32;
	localparam int TYPE_LSB    = 24;
	localparam int TYPE_W      = 3;
	localparam int CHAN_LSB    = 17;
	localparam int CHAN_W      = 4;
	localparam int RANGE_BIT   = 16;

	// Word type codes
	localparam logic [TYPE_W-1:0] TYPE_HEADER  = 3'h2;
	localparam logic [TYPE_W-1:0] TYPE_DATA    = 3'h0;
	localparam logic [TYPE_W-1:0] TYPE_TRAILER = 3'h4;

	// Result field widths
	localparam int OUT_CH_W  = 5;
	localparam int OUT_VAL_W = 12;

	// Hard ceiling on addressable logical channels (5-bit channel number)
	localparam int CHAN_LIMIT = 32;

	// Configuration registers
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int VBITS_W     = 5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_BITS  = 1'd1;
	localparam logic [VBITS_W-1:0]   VBITS_RESET     = 5'd12;

	// Decoded view of one readout word
	typedef struct packed {
		logic                is_header;
		logic                is_data;
		logic                is_trailer;
		logic [OUT_CH_W-1:0] chan;
		logic                chan_ok;
		logic                fits;
	} word_info_t;

endpackage

// ===== src/qdc_word_decode.sv =====
// ----------------------------------------------------------------------------
// qdc_word_decode
// Splits a readout word into type flags, logical channel and value, and
// checks the channel range and the value limit.
// ----------------------------------------------------------------------------
module qdc_word_decode #(
	parameter int LOGICAL_CHANNELS = qdc_pkg::LOGICAL_CHANNELS_DEF,
	parameter int VALUE_WIDTH      = qdc_pkg::VALUE_WIDTH_DEF
) (
	input  logic [qdc_pkg::WORD_W-1:0]  data_word,
	input  logic [qdc_pkg::VBITS_W-1:0] value_bits,
	output qdc_pkg::word_info_t         info,
	output logic [VALUE_WIDTH-1:0]      value
);
	import qdc_pkg::*;

	localparam int NUM_CH = (LOGICAL_CHANNELS < CHAN_LIMIT) ? LOGICAL_CHANNELS : CHAN_LIMIT;
	localparam logic [OUT_CH_W:0]  NUM_CH_V = (OUT_CH_W+1)'(NUM_CH);
	localparam logic [VBITS_W-1:0] VW_V     = VBITS_W'(VALUE_WIDTH);

	logic [TYPE_W-1:0]   wtype;
	logic [OUT_CH_W-1:0] chan;

	assign wtype = data_word[TYPE_LSB +: TYPE_W];
	assign value = data_word[VALUE_WIDTH-1:0];

	// Range bit clear selects the high range, which sits 16 channels up
	assign chan = {~data_word[RANGE_BIT], data_word[CHAN_LSB +: CHAN_W]};

	always_comb begin
		info.is_header  = (wtype == TYPE_HEADER);
		info.is_data    = (wtype == TYPE_DATA);
		info.is_trailer = (wtype == TYPE_TRAILER);
		info.chan       = chan;
		info.chan_ok    = ({1'b0, chan} < NUM_CH_V);
		// Limit at or above the value width passes everything
		info.fits       = (value_bits >= VW_V) || ((value >> value_bits) == '0);
	end

endmodule

// ===== src/qdc_drain_seq.sv =====
// ----------------------------------------------------------------------------
// qdc_drain_seq
// Event state, per-channel present bits and value store, and the sequencer
// that walks the store one channel per scan cycle when a trailer closes an event.
// ----------------------------------------------------------------------------
module qdc_drain_seq #(
	parameter int LOGICAL_CHANNELS = qdc_pkg::LOGICAL_CHANNELS_DEF,
	parameter int VALUE_WIDTH      = qdc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  qdc_pkg::word_info_t            info,
	input  logic [VALUE_WIDTH-1:0]         value,
	input  logic [qdc_pkg::CFG_DATA_W-1:0] chan_mask,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [qdc_pkg::OUT_CH_W-1:0]   channel_index,
	output logic [qdc_pkg::OUT_VAL_W-1:0]  channel_value,
	output logic                           last_of_event
);
	import qdc_pkg::*;

	localparam int NUM_CH = (LOGICAL_CHANNELS < CHAN_LIMIT) ? LOGICAL_CHANNELS : CHAN_LIMIT;
	localparam int IDX_W  = $clog2(NUM_CH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH
	} state_t;

	state_t                 state_q;
	logic                   inside_q;
	logic [NUM_CH-1:0]      present_q;
	logic [NUM_CH-1:0]      pend_q;
	logic [IDX_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [OUT_CH_W-1:0]    ch_out_q;
	logic [OUT_VAL_W-1:0]   val_out_q;
	logic                   last_out_q;

	logic [VALUE_WIDTH-1:0] store_mem [NUM_CH];
	logic [VALUE_WIDTH-1:0] rd_data_q;

	logic                   accept;
	logic                   active;
	logic [IDX_W-1:0]       wr_idx;
	logic                   wr_en;
	logic                   out_free;
	logic                   out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign active   = (chan_mask != '0);
	assign wr_idx   = info.chan[IDX_W-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_FETCH) && out_free;

	// First valid value of a channel in an open event is stored
	assign wr_en = accept && info.is_data && inside_q && active && info.chan_ok &&
		info.fits && !present_q[wr_idx];

	// Value store: one write port, registered read at the scan pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_idx] <= value;
		end
		rd_data_q <= store_mem[cnt_q];
	end

	// Sequencer, event state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inside_q    <= 1'b0;
			present_q   <= '0;
			pend_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			ch_out_q    <= '0;
			val_out_q   <= '0;
			last_out_q  <= 1'b0;
		end else begin
			// Result register: load from fetch, or empty once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				ch_out_q    <= OUT_CH_W'(cnt_q);
				val_out_q   <= OUT_VAL_W'(rd_data_q);
				last_out_q  <= ((pend_q >> 1) == '0);
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (info.is_header && !inside_q) begin
							inside_q <= 1'b1;
							if (active) begin
								present_q <= '0;
							end
						end else if (wr_en) begin
							present_q[wr_idx] <= 1'b1;
						end else if (info.is_trailer && inside_q) begin
							inside_q <= 1'b0;
							if (active) begin
								pend_q  <= present_q & chan_mask[NUM_CH-1:0];
								cnt_q   <= '0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (pend_q == '0) begin
						state_q <= ST_IDLE;
					end else if (pend_q[0]) begin
						// store read at cnt_q lands in rd_data_q this edge
						state_q <= ST_FETCH;
					end else begin
						pend_q <= pend_q >> 1;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ST_FETCH: begin
					if (out_load) begin
						pend_q  <= pend_q >> 1;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_index = ch_out_q;
	assign channel_value = val_out_q;
	assign last_of_event = last_out_q;

	// Drain only visits channels that hold a value; pend_q bit i is channel cnt_q + i
	a_pend_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((pend_q & ~(present_q >> cnt_q)) == '0))
		else $error("pending channel without stored value");

	// A pending channel at the scan pointer goes to fetch
	a_scan_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pend_q[0]) |=> (state_q == ST_FETCH))
		else $error("scan skipped a pending channel");

	// Fetch holds while the result register is occupied
	a_fetch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH && out_valid_q && !out_ready) |=>
		(state_q == ST_FETCH && $stable(cnt_q)))
		else $error("fetch overran a pending result");

	// A result marked last leaves nothing pending
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH && out_free && (pend_q >> 1) == '0) |=> (pend_q == '0))
		else $error("last result with channels still pending");

endmodule

// ===== src/qdc_event_word_demux.sv =====
// ----------------------------------------------------------------------------
// qdc_event_word_demux
// Demultiplexer for event words of a dual-range charge converter.
// ----------------------------------------------------------------------------
// Header, data and other words are taken one per cycle while the sequencer
// is idle. A trailer that closes an event with a nonzero enable mask starts
// a drain of the value store: the sequencer steps through the logical
// channels one per cycle, adds a fetch step per emitted value for the
// registered store read, and holds the input until the drain ends, output
// stalls included. The drain ends right after the highest pending channel.
// Values come out in ascending channel order, last_of_event on the final one;
// a finished result waits in an output register while new words are accepted.
// ----------------------------------------------------------------------------
module qdc_event_word_demux #(
	parameter int LOGICAL_CHANNELS = qdc_pkg::LOGICAL_CHANNELS_DEF,
	parameter int VALUE_WIDTH      = qdc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// word input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [qdc_pkg::WORD_W-1:0]     data_word,
	// result output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [qdc_pkg::OUT_CH_W-1:0]   channel_index,
	output logic [qdc_pkg::OUT_VAL_W-1:0]  channel_value,
	output logic                           last_of_event,
	// configuration
	input  logic                           cfg_we,
	input  logic [qdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import qdc_pkg::*;

	logic [CFG_DATA_W-1:0]  mask_q;
	logic [VBITS_W-1:0]     vbits_q;
	word_info_t             info;
	logic [VALUE_WIDTH-1:0] value;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			vbits_q <= VBITS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE_MASK: mask_q  <= cfg_wdata;
				REG_VALUE_BITS:  vbits_q <= cfg_wdata[VBITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Word decode
	qdc_word_decode #(
		.LOGICAL_CHANNELS (LOGICAL_CHANNELS),
		.VALUE_WIDTH      (VALUE_WIDTH)
	) u_decode (
		.data_word  (data_word),
		.value_bits (vbits_q),
		.info       (info),
		.value      (value)
	);

	// Event state, store and drain sequencer
	qdc_drain_seq #(
		.LOGICAL_CHANNELS (LOGICAL_CHANNELS),
		.VALUE_WIDTH      (VALUE_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.info          (info),
		.value         (value),
		.chan_mask     (mask_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_of_event (last_of_event)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for qdc_event_word_demux. Readout words go in over a
// valid/ready channel: header, data and trailer words, broken and stray
// sequences and other word types. A scoreboard keeps its own copy of the
// event state and the per-channel store, predicts the channel values that
// each trailer drains, and checks every result in order. Both sides idle at
// random, and the registers are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import qdc_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 6;
	localparam int MAX_IDLE     = 15;
	localparam int DRAIN_CYCLES = 2 * CHAN_LIMIT + 8;
	localparam int CYCLE_LIMIT  = 1000000;

	// One channel value drained by a trailer
	typedef struct packed {
		logic [OUT_CH_W-1:0]  ch;
		logic [OUT_VAL_W-1:0] value;
		logic                 last;
	} chan_result_t;

	// Event scoreboard: tracks event state and stored values, holds the
	// channel values still to come out of the block
	class event_scoreboard;
		logic [CFG_DATA_W-1:0]  enable_mask;
		logic [VBITS_W-1:0]     value_bits;
		bit                     event_open;
		logic [CHAN_LIMIT-1:0]  filled;
		logic [OUT_VAL_W-1:0]   stored [CHAN_LIMIT];
		chan_result_t           expected_q [$];
		int                     errors;
		int                     words;
		int                     events;
		int                     checked;

		function new();
			enable_mask = '0;
			value_bits  = VBITS_RESET;
			event_open  = 1'b0;
			filled      = '0;
			for (int c = 0; c < CHAN_LIMIT; c++)
				stored[c] = '0;
			errors  = 0;
			words   = 0;
			events  = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
			if (idx == REG_ENABLE_MASK)
				enable_mask = wdata;
			else
				value_bits = wdata[VBITS_W-1:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Update the event state for one request; a closing trailer queues
		// the enabled stored values in ascending channel order
		function void note_request(logic [WORD_W-1:0] w);
			logic [TYPE_W-1:0]    kind;
			logic [OUT_CH_W-1:0]  ch;
			logic [OUT_VAL_W-1:0] v;
			logic [CHAN_LIMIT-1:0] hits;
			chan_result_t         r;
			bit                   fits;
			kind = w[TYPE_LSB +: TYPE_W];
			words++;
			if (kind == TYPE_HEADER) begin
				if (!event_open) begin
					event_open = 1'b1;
					if (enable_mask != 0)
						filled = '0;
				end
			end else if (kind == TYPE_DATA) begin
				if (event_open && enable_mask != 0) begin
					v    = w[OUT_VAL_W-1:0];
					// low range is bit set; high range maps to channel + 16
					ch   = {~w[RANGE_BIT], w[CHAN_LSB +: CHAN_W]};
					fits = (value_bits >= VALUE_WIDTH_DEF) ||
						({20'd0, v} < (32'd1 << value_bits));
					if (fits && !filled[ch]) begin
						filled[ch] = 1'b1;
						stored[ch] = v;
					end
				end
			end else if (kind == TYPE_TRAILER) begin
				if (event_open) begin
					event_open = 1'b0;
					events++;
					if (enable_mask != 0) begin
						hits = filled & enable_mask;
						for (int c = 0; c < CHAN_LIMIT; c++) begin
							if (hits[c]) begin
								r.ch    = c[OUT_CH_W-1:0];
								r.value = stored[c];
								r.last  = ((hits >> (c + 1)) == 0);
								expected_q.push_back(r);
							end
						end
					end
				end
			end
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(logic [OUT_CH_W-1:0] ch, logic [OUT_VAL_W-1:0] value,
				logic last);
			chan_result_t exp_r;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result channel_index=%0d channel_value=%h last=%b",
					$time, ch, value, last);
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			if (ch !== exp_r.ch) begin
				errors++;
				$display("%0t: channel_index expected %0d actual %0d", $time, exp_r.ch, ch);
			end
			if (value !== exp_r.value) begin
				errors++;
				$display("%0t: channel_value expected %h actual %h (channel %0d)",
					$time, exp_r.value, value, exp_r.ch);
			end
			if (last !== exp_r.last) begin
				errors++;
				$display("%0t: last_of_event expected %b actual %b (channel %0d)",
					$time, exp_r.last, last, exp_r.ch);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [WORD_W-1:0]     data_word;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_CH_W-1:0]   channel_index;
	logic [OUT_VAL_W-1:0]  channel_value;
	logic                  last_of_event;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	event_scoreboard sb;
	bit              idle_on;
	int              cycle_count = 0;
	int              settings = 0;

	qdc_event_word_demux u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_word     (data_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_of_event (last_of_event),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, sb.pending());
			$display("FAIL");
			$finish;
		end
	end

	// Word builders: bits outside the decoded fields stay random
	function automatic logic [WORD_W-1:0] make_word(logic [TYPE_W-1:0] kind);
		logic [WORD_W-1:0] w;
		w = $urandom;
		w[TYPE_LSB +: TYPE_W] = kind;
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] make_data(logic [CHAN_W-1:0] ch, logic rng,
			logic [OUT_VAL_W-1:0] value);
		logic [WORD_W-1:0] w;
		w = make_word(TYPE_DATA);
		w[CHAN_LSB +: CHAN_W] = ch;
		w[RANGE_BIT] = rng;
		w[OUT_VAL_W-1:0] = value;
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] make_noise();
		logic [TYPE_W-1:0] kind;
		kind = TYPE_W'($urandom_range(0, 7));
		while (kind == TYPE_HEADER || kind == TYPE_DATA || kind == TYPE_TRAILER)
			kind = TYPE_W'($urandom_range(0, 7));
		return make_word(kind);
	endfunction

	// Values biased toward the value_bits threshold
	function automatic logic [WORD_W-1:0] make_random_data();
		int                   lim;
		logic [OUT_VAL_W-1:0] v;
		lim = (sb.value_bits >= VALUE_WIDTH_DEF) ? (1 << VALUE_WIDTH_DEF) :
			(1 << sb.value_bits);
		case ($urandom_range(0, 3))
			0: v = OUT_VAL_W'($urandom_range(0, lim - 1));
			1: v = OUT_VAL_W'(lim - 1 + int'($urandom_range(0, 1)));
			default: v = OUT_VAL_W'($urandom);
		endcase
		return make_data(CHAN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), v);
	endfunction

	// Present one request; the prediction is made on presentation and the
	// word is held until the block takes it
	task automatic send_word(input logic [WORD_W-1:0] w);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_word <= w;
		sb.note_request(w);
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// Drop valid and hold until every expected result is out
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] wdata);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= wdata;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, wdata);
	endtask

	// Registers change only with the block idle, after any trailing drain
	task automatic configure(input logic [CFG_DATA_W-1:0] mask,
			input logic [VBITS_W-1:0] vbits);
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_ENABLE_MASK, mask);
		write_reg(REG_VALUE_BITS, {27'd0, vbits});
		settings++;
	endtask

	// Directed words: field extremes and each ignored or dropped case
	task automatic run_directed();
		send_word(make_data(4'd3, 1'b1, 12'h010));   // data outside an event
		send_word(make_word(TYPE_TRAILER));          // trailer outside an event
		send_word(32'h0000_0000);                    // all-zero data, outside
		send_word(make_noise());
		send_word(make_word(TYPE_HEADER));
		send_word(make_word(TYPE_HEADER));           // header inside an event
		send_word(make_data(4'd0, 1'b1, 12'h000));   // channel 0
		send_word(make_data(4'd15, 1'b1, 12'hfff));  // channel 15
		send_word(make_data(4'd0, 1'b0, 12'hfff));   // channel 16
		send_word(make_data(4'd15, 1'b0, 12'h123));  // channel 31
		send_word(make_data(4'd0, 1'b1, 12'h555));   // already filled, dropped
		send_word(32'hffff_ffff);                    // other type inside event
		send_word(make_word(TYPE_TRAILER));
		hold_until_drained();
		// event with nothing stored
		send_word(make_word(TYPE_HEADER));
		send_word(make_word(TYPE_TRAILER));
		// one-bit value range
		configure(32'hffff_ffff, 5'd1);
		send_word(make_word(TYPE_HEADER));
		send_word(make_data(4'd5, 1'b1, 12'h001));
		send_word(make_data(4'd6, 1'b1, 12'h002));   // too large, dropped
		send_word(make_data(4'd7, 1'b0, 12'h000));
		send_word(make_data(4'd8, 1'b1, 12'hfff));   // too large, dropped
		send_word(make_word(TYPE_TRAILER));
	endtask

	// Mostly complete events with random content, plus noise, stray words,
	// repeated headers and events left open
	task automatic run_random(input int quota);
		int sent;
		int nwords;
		sent = 0;
		while (sent < quota) begin
			case ($urandom_range(0, 9))
				0: send_word(make_noise());
				1: send_word($urandom_range(0, 1) ? make_word(TYPE_TRAILER) : make_random_data());
				2: send_word(make_word(TYPE_HEADER));
				default: begin
					nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 48) :
						$urandom_range(0, 8);
					send_word(make_word(TYPE_HEADER));
					for (int j = 0; j < nwords; j++) begin
						case ($urandom_range(0, 19))
							0: send_word(make_word(TYPE_HEADER));
							1: send_word(make_noise());
							default: send_word(make_random_data());
						endcase
					end
					if ($urandom_range(0, 9) != 0)
						send_word(make_word(TYPE_TRAILER));
					sent += nwords + 2;
					if ($urandom_range(0, 7) == 0)
						hold_until_drained();
				end
			endcase
		end
	endtask

	// Result sink with random back-pressure
	initial begin : result_sink
		int stall;
		forever begin
			stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result(channel_index, channel_value, last_of_event);
		end
	end

	// Main sequence
	initial begin
		sb        = new();
		idle_on   = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_word = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(32'hffff_ffff, 5'd12);
		run_directed();

		idle_on = 1'b1;
		configure(32'hffff_ffff, 5'd16);
		run_random(20);

		idle_on = 1'b0;
		configure($urandom, VBITS_W'($urandom_range(1, 16)));
		run_random(20);

		// per-channel processing off: store is neither cleared nor filled
		idle_on = 1'b1;
		configure(32'h0000_0000, 5'd12);
		run_random(15);

		configure(32'h8000_0001, 5'd1);
		run_random(20);

		idle_on = 1'b0;
		configure($urandom, 5'd12);
		run_random(20);

		idle_on = 1'b1;
		configure(32'hffff_ffff, VBITS_W'($urandom_range(1, 16)));
		run_random(30);

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d words and %0d closed events over %0d register settings,",
			sb.words, sb.events, settings);
		$display("with %0d channel values checked and %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== qdc_event_word_demux.f =====
src/qdc_pkg.sv
src/qdc_word_decode.sv
src/qdc_drain_seq.sv
src/qdc_event_word_demux.sv
tb/testbench.sv
